### rtl/free_list_object_allocator_top_defines.svh
// Assertion macros used by the checker file.
`ifndef FREE_LIST_OBJECT_ALLOCATOR_TOP_DEFINES_SVH
`define FREE_LIST_OBJECT_ALLOCATOR_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define FLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define FLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fla_pkg.sv
package fla_pkg;

    localparam int POOL_RESET = 256;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic latch;
        logic emit_single;
        logic issue_read;
        logic emit_grant;
    } t_dp_cmd;

    typedef struct packed {
        t_status code;
        logic    is_free;
        logic    more;
    } t_dp_stat;

endpackage

### rtl/fla_ctrl.sv
module fla_ctrl
    import fla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output logic     busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_GRANT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.code != ST_OK || i_stat.is_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.issue_read = 1'b1;
                    n_state          = S_GRANT;
                end
            end
            S_GRANT: begin
                o_cmd.emit_grant = 1'b1;
                if (i_stat.more) begin
                    o_cmd.issue_read = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/fla_datapath.sv
module fla_datapath
    import fla_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int MAX_RUN    = 16,
    parameter int IDX_W      = 8,
    parameter int CNT_W      = 9,
    parameter int RUN_W      = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_kind,
    input  logic [RUN_W-1:0] i_count,
    input  logic [IDX_W-1:0] i_slot_index,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_granted_slot,
    output logic             o_last,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_free_slots,
    output logic [CNT_W-1:0] o_used_slots
);

    localparam int RST_POOL = (POOL_RESET > POOL_DEPTH) ? POOL_DEPTH : POOL_RESET;

    logic [IDX_W-1:0] r_ring [POOL_DEPTH];

    logic [CNT_W-1:0] r_pool_size;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_free;
    logic             r_wrapped;
    logic [RUN_W-1:0] r_remain;

    logic             r_kind;
    logic [RUN_W-1:0] r_count;
    logic [IDX_W-1:0] r_slot;

    logic [IDX_W-1:0] r_rdata;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_fill;

    logic [CNT_W-1:0] cfg_clamped;
    logic [CNT_W-1:0] head_p1;
    logic [CNT_W-1:0] tail_p1;
    logic [IDX_W-1:0] head_nxt;
    logic [IDX_W-1:0] tail_nxt;
    logic             tail_wrap;
    t_status          code;
    logic             do_push;
    logic [CNT_W-1:0] single_free;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (i_cfg_wdata > CNT_W'(POOL_DEPTH)) begin
            cfg_clamped = CNT_W'(POOL_DEPTH);
        end else begin
            cfg_clamped = i_cfg_wdata;
        end
    end

    assign head_p1   = CNT_W'(r_head) + CNT_W'(1);
    assign tail_p1   = CNT_W'(r_tail) + CNT_W'(1);
    assign head_nxt  = (head_p1 >= r_pool_size) ? '0 : IDX_W'(head_p1);
    assign tail_wrap = (tail_p1 >= r_pool_size);
    assign tail_nxt  = tail_wrap ? '0 : IDX_W'(tail_p1);

    always_comb begin
        if (r_kind) begin
            if (r_free >= r_pool_size) begin
                code = ST_FULL;
            end else if (CNT_W'(r_slot) >= r_pool_size) begin
                code = ST_RANGE;
            end else begin
                code = ST_OK;
            end
        end else begin
            if (r_count == '0 || r_count > RUN_W'(MAX_RUN)) begin
                code = ST_RANGE;
            end else if (32'(r_free) < 32'(r_count)) begin
                code = ST_OOM;
            end else begin
                code = ST_OK;
            end
        end
    end

    assign o_stat.code    = code;
    assign o_stat.is_free = r_kind;
    assign o_stat.more    = (r_remain != '0);

    assign do_push     = i_cmd.emit_single && r_kind && (code == ST_OK);
    assign single_free = do_push ? (r_free + CNT_W'(1)) : r_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= CNT_W'(RST_POOL);
            r_head      <= '0;
            r_tail      <= '0;
            r_free      <= CNT_W'(RST_POOL);
            r_wrapped   <= 1'b0;
            r_remain    <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_single || i_cmd.emit_grant;
            if (i_cfg_we) begin
                r_pool_size <= cfg_clamped;
                r_head      <= '0;
                r_tail      <= '0;
                r_free      <= cfg_clamped;
                r_wrapped   <= 1'b0;
            end else begin
                if (i_cmd.latch) begin
                    r_remain <= i_count;
                end
                if (do_push) begin
                    r_tail    <= tail_nxt;
                    r_wrapped <= r_wrapped || tail_wrap;
                    r_free    <= r_free + CNT_W'(1);
                end
                if (i_cmd.issue_read) begin
                    r_head   <= head_nxt;
                    r_free   <= r_free - CNT_W'(1);
                    r_remain <= r_remain - RUN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_count <= i_count;
            r_slot  <= i_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push && !i_cfg_we) begin
            r_ring[r_tail] <= r_slot;
        end
        if (i_cmd.issue_read) begin
            r_rdata   <= r_ring[r_head];
            r_rd_idx  <= r_head;
            r_rd_fill <= r_wrapped || (r_head < r_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            o_granted_slot <= '0;
            o_last         <= 1'b1;
            o_status       <= code;
            o_free_slots   <= single_free;
            o_used_slots   <= r_pool_size - single_free;
        end else if (i_cmd.emit_grant) begin
            o_granted_slot <= r_rd_fill ? r_rdata : r_rd_idx;
            o_last         <= (r_remain == '0);
            o_status       <= ST_OK;
            o_free_slots   <= r_free;
            o_used_slots   <= r_pool_size - r_free;
        end
    end

endmodule

### rtl/free_list_object_allocator_top.sv
// Ring free-list slot allocator.
// Command channel: an allocate (i_kind 0, i_count slots) or free (i_kind 1,
// i_slot_index) transaction is taken at a clock edge with start high and busy low.
// Result channel: o_valid marks each result for exactly one cycle; the receiver
// cannot stall it. An allocate gives one result per granted slot with o_last on
// the final one; errors and frees give a single result with o_last set.
// Sequence: the command edge moves the controller to its check state. A free or
// a rejected request gets its result from there through the output register;
// an allocate issues its first ring memory read there, then a grant state emits
// the grants, one ring memory read per granted slot. busy falls in the cycle that
// shows the last result, so the next command can be taken there.
// Configuration: i_cfg_we with i_cfg_wdata sets the pool size (clamped to
// 1..POOL_DEPTH) and rebuilds the ring at once; write it only while idle.
// Reset sets the pool size to 256 (or POOL_DEPTH if smaller) with every slot
// free. Ring entries never written since the last rebuild read as their own
// index through the tail pointer and a wrap flag, so no clearing pass is needed.
module free_list_object_allocator_top
    import fla_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int MAX_RUN    = 16,
    localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1),
    localparam int RUN_W     = $clog2(MAX_RUN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic             i_kind,
    input  logic [RUN_W-1:0] i_count,
    input  logic [IDX_W-1:0] i_slot_index,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_granted_slot,
    output logic             o_last,
    output logic [1:0]       o_status,
    output logic [CNT_W-1:0] o_free_slots,
    output logic [CNT_W-1:0] o_used_slots
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    fla_datapath #(
        .POOL_DEPTH (POOL_DEPTH),
        .MAX_RUN    (MAX_RUN),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .RUN_W      (RUN_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_count        (i_count),
        .i_slot_index   (i_slot_index),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_granted_slot (o_granted_slot),
        .o_last         (o_last),
        .o_status       (o_status),
        .o_free_slots   (o_free_slots),
        .o_used_slots   (o_used_slots)
    );

endmodule

### rtl/fla_checker.sv
`include "free_list_object_allocator_top_defines.svh"

module fla_checker
    import fla_pkg::*;
#(
    parameter int POOL_DEPTH = 256,
    parameter int MAX_RUN    = 16,
    localparam int IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int CNT_W     = $clog2(POOL_DEPTH + 1),
    localparam int RUN_W     = $clog2(MAX_RUN + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [CNT_W-1:0] i_cfg_wdata,
    input logic             start,
    input logic             busy,
    input logic             i_kind,
    input logic [RUN_W-1:0] i_count,
    input logic [IDX_W-1:0] i_slot_index,
    input logic             o_valid,
    input logic [IDX_W-1:0] o_granted_slot,
    input logic             o_last,
    input logic [1:0]       o_status,
    input logic [CNT_W-1:0] o_free_slots,
    input logic [CNT_W-1:0] o_used_slots
);

    // A rejected request is one final result that grants nothing.
    `FLA_ASSERT(a_err_single, (o_valid && o_status != ST_OK) |-> (o_last && o_granted_slot == '0), "error result is not a single empty result")

    // The results of a run follow each other without a gap.
    `FLA_ASSERT_NEXT(a_run_gapless, o_valid && !o_last, o_valid, "gap inside an allocation run")

    // A taken command keeps the block busy in the next cycle.
    `FLA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy did not rise after a command")

    // busy drops exactly with the final result of a transaction.
    `FLA_ASSERT(a_last_frees, o_valid |-> (o_last == !busy), "busy does not match the last flag")

endmodule

bind free_list_object_allocator_top fla_checker #(
    .POOL_DEPTH (POOL_DEPTH),
    .MAX_RUN    (MAX_RUN)
) u_fla_checker (.*);

### tb/tb_free_list_object_allocator_top.sv
module tb_free_list_object_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fla_pkg::*;

    localparam int POOL_DEPTH = 256;
    localparam int MAX_RUN    = 16;

    typedef struct {
        logic       kind;
        logic [4:0] count;
        logic [7:0] slot;
    } t_request;

    typedef struct {
        logic [7:0] slot;
        logic       last;
        t_status    status;
        logic [8:0] free_slots;
        logic [8:0] used_slots;
    } t_grant;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [8:0] i_cfg_wdata  = '0;
    logic       start        = 1'b0;
    logic       busy;
    logic       i_kind       = 1'b0;
    logic [4:0] i_count      = '0;
    logic [7:0] i_slot_index = '0;
    logic       o_valid;
    logic [7:0] o_granted_slot;
    logic       o_last;
    logic [1:0] o_status;
    logic [8:0] o_free_slots;
    logic [8:0] o_used_slots;

    free_list_object_allocator_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_count(i_count),
        .i_slot_index(i_slot_index),
        .o_valid(o_valid),
        .o_granted_slot(o_granted_slot),
        .o_last(o_last),
        .o_status(o_status),
        .o_free_slots(o_free_slots),
        .o_used_slots(o_used_slots)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] pool_ring [POOL_DEPTH];
    int         pool_head;
    int         pool_tail;
    int         pool_free;
    int         pool_limit;
    logic [7:0] held_slots [$];

    t_request   pending_requests [$];
    t_grant     grants_due [$];
    bit         cmd_taken;
    int         send_gap_pct;

    int         n_requests;
    int         n_results;
    int         n_pool_writes;
    int         n_status [4];
    int         n_mismatch;

    function automatic int ring_advance(int p);
        p++;
        if (p >= pool_limit) begin
            p = 0;
        end
        return p;
    endfunction

    function automatic void rebuild_pool(int size);
        if (size < 1) begin
            size = 1;
        end
        if (size > POOL_DEPTH) begin
            size = POOL_DEPTH;
        end
        pool_limit = size;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            pool_ring[i] = 8'(i);
        end
        pool_head = 0;
        pool_tail = 0;
        pool_free = size;
        held_slots.delete();
    endfunction

    function automatic void push_grant(int slot, bit last, t_status status);
        t_grant g;
        g.slot       = 8'(slot);
        g.last       = last;
        g.status     = status;
        g.free_slots = 9'(pool_free);
        g.used_slots = 9'(pool_limit - pool_free);
        grants_due.push_back(g);
    endfunction

    function automatic void predict_grants(logic kind, logic [4:0] count, logic [7:0] slot);
        int g;
        if (!kind) begin
            if (count == 0 || count > MAX_RUN) begin
                push_grant(0, 1'b1, ST_RANGE);
            end else if (pool_free < count) begin
                push_grant(0, 1'b1, ST_OOM);
            end else begin
                for (int k = 0; k < count; k++) begin
                    g = pool_ring[pool_head];
                    pool_head = ring_advance(pool_head);
                    pool_free--;
                    held_slots.push_back(8'(g));
                    push_grant(g, k == count - 1, ST_OK);
                end
            end
        end else if (pool_free >= pool_limit) begin
            push_grant(0, 1'b1, ST_FULL);
        end else if (slot >= pool_limit) begin
            push_grant(0, 1'b1, ST_RANGE);
        end else begin
            pool_ring[pool_tail] = slot;
            pool_tail = ring_advance(pool_tail);
            pool_free++;
            push_grant(0, 1'b1, ST_OK);
        end
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || cmd_taken) begin
            cmd_taken = 1'b0;
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                start        <= 1'b1;
                i_kind       <= pending_requests[0].kind;
                i_count      <= pending_requests[0].count;
                i_slot_index <= pending_requests[0].slot;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant e;
        if (!i_rst_n) begin
            rebuild_pool(POOL_RESET);
            grants_due.delete();
        end else begin
            if (o_valid) begin
                n_results++;
                if (grants_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("%0t: unexpected result slot=%0d last=%0d status=%0d",
                                 $realtime, o_granted_slot, o_last, o_status);
                    end
                end else begin
                    e = grants_due.pop_front();
                    n_status[e.status]++;
                    if (o_granted_slot !== e.slot || o_last !== e.last
                            || o_status !== e.status || o_free_slots !== e.free_slots
                            || o_used_slots !== e.used_slots) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("%0t: mismatch exp slot=%0d last=%0d status=%0d free=%0d used=%0d",
                                     $realtime, e.slot, e.last, e.status, e.free_slots,
                                     e.used_slots);
                            $display("%0t:          got slot=%0d last=%0d status=%0d free=%0d used=%0d",
                                     $realtime, o_granted_slot, o_last, o_status,
                                     o_free_slots, o_used_slots);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                rebuild_pool(int'(i_cfg_wdata));
                n_pool_writes++;
            end
            if (start && !busy) begin
                predict_grants(i_kind, i_count, i_slot_index);
                void'(pending_requests.pop_front());
                n_requests++;
                cmd_taken = 1'b1;
            end
        end
    end

    task automatic send(logic kind, logic [4:0] count, logic [7:0] slot);
        t_request r;
        while (pending_requests.size() >= 2) begin
            @(posedge i_clk);
        end
        r.kind  = kind;
        r.count = count;
        r.slot  = slot;
        pending_requests.push_back(r);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || start || grants_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_pool(int value);
        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 9'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random();
        int         j;
        int         bias;
        logic [7:0] slot;
        logic [4:0] cnt;
        bias = (pool_free * 2 < pool_limit) ? 75 : 35;
        if ($urandom_range(99) < 8) begin
            send(1'($urandom_range(1)), 5'($urandom_range(31)), 8'($urandom_range(255)));
        end else if (held_slots.size() > 0 && $urandom_range(99) < bias) begin
            j = $urandom_range(held_slots.size() - 1);
            slot = held_slots[j];
            held_slots.delete(j);
            send(1'b1, 5'($urandom_range(31)), slot);
        end else begin
            cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(MAX_RUN, 1))
                                           : 5'($urandom_range(4, 1));
            send(1'b0, cnt, 8'($urandom_range(255)));
        end
    endtask

    int pool_plan [8] = '{256, 2, 17, 1, 5, 300, 64, 0};

    initial begin
        send_gap_pct = 36;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(1'b1, 5'd0, 8'd0);
        send(1'b0, 5'd0, 8'd0);
        send(1'b0, 5'd17, 8'd0);
        send(1'b0, 5'd31, 8'd255);
        send(1'b0, 5'd1, 8'd0);
        send(1'b0, 5'd16, 8'd0);
        send(1'b1, 5'd0, 8'd255);
        send(1'b1, 5'd0, 8'd5);
        send(1'b1, 5'd0, 8'd5);

        write_pool(4);
        send(1'b0, 5'd5, 8'd0);
        send(1'b0, 5'd4, 8'd0);
        send(1'b1, 5'd0, 8'd4);
        send(1'b1, 5'd0, 8'd255);
        send(1'b1, 5'd0, 8'd3);
        send(1'b1, 5'd0, 8'd3);
        send(1'b0, 5'd3, 8'd0);
        send(1'b0, 5'd2, 8'd0);

        write_pool(0);
        send(1'b0, 5'd1, 8'd0);
        send(1'b0, 5'd1, 8'd0);
        send(1'b1, 5'd0, 8'd1);
        send(1'b1, 5'd0, 8'd0);
        send(1'b1, 5'd0, 8'd0);

        write_pool(511);
        send(1'b0, 5'd16, 8'd0);

        for (int p = 0; p < 8; p++) begin
            write_pool((p == 7) ? $urandom_range(256, 1) : pool_plan[p]);
            send_gap_pct = (p < 3) ? 36 : (p < 6) ? 65 : 0;
            repeat (55) send_random();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (grants_due.size() != 0) begin
            n_mismatch++;
        end

        $display("Covered %0d requests and %0d results over %0d pool size writes.",
                 n_requests, n_results, n_pool_writes);
        $display("Results by status: ok %0d, out of memory %0d, full %0d, out of range %0d.",
                 n_status[ST_OK], n_status[ST_OOM], n_status[ST_FULL], n_status[ST_RANGE]);
        if (n_mismatch == 0) begin
            $display("[free_list_object_allocator_top] OK");
        end else begin
            $display("[free_list_object_allocator_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[free_list_object_allocator_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fla_pkg.sv
rtl/fla_ctrl.sv
rtl/fla_datapath.sv
rtl/free_list_object_allocator_top.sv
rtl/fla_checker.sv
tb/tb_free_list_object_allocator_top.sv
